### hw/rtl/send_on_delta_drive_recorder_macros.svh
// Assertion macros for the send-on-delta drive recorder.
`ifndef SEND_ON_DELTA_DRIVE_RECORDER_MACROS_SVH
`define SEND_ON_DELTA_DRIVE_RECORDER_MACROS_SVH
`ifndef SYNTH
`define SODR_ASSERT(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("assertion failed");
`define SODR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SODR_ASSERT(lbl, clk, rstn, expr)
`define SODR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hw/rtl/sodr_pkg.sv
// Shared constants and types of the send-on-delta drive recorder.
package sodr_pkg;

  localparam int TICK_BITS_DEF   = 16;
  localparam int SAMPLE_BITS_DEF = 15;

  localparam int WIN_W      = 16;
  localparam int THR_W      = 15;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [WIN_W-1:0] WIN_RESET = 16'd300;
  localparam logic [THR_W-1:0] THR_RESET = 15'd15;

  localparam logic EVT_RECORD     = 1'b0;
  localparam logic EVT_WINDOW_END = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICKS_IN_WINDOW  = 1'b0,
    REG_CHANGE_THRESHOLD = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic left;
    logic right;
  } lane_hits_t;

endpackage

### hw/rtl/sodr_in_if.sv
// Input channel: one sampling tick with the left and right drive voltages.
interface sodr_in_if #(
  parameter int SAMPLE_BITS = 15
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_voltage;
  logic signed [SAMPLE_BITS-1:0] right_voltage;

  modport source (output valid, output left_voltage, output right_voltage, input ready);
  modport sink (input valid, input left_voltage, input right_voltage, output ready);
endinterface

### hw/rtl/sodr_out_if.sv
// Output channel: one record or window-end event.
interface sodr_out_if #(
  parameter int TICK_BITS   = 16,
  parameter int SAMPLE_BITS = 15
);
  logic                          valid;
  logic                          ready;
  logic                          event_kind;
  logic [TICK_BITS-1:0]          record_tick;
  logic signed [SAMPLE_BITS-1:0] record_left;
  logic signed [SAMPLE_BITS-1:0] record_right;

  modport source (output valid, output event_kind, output record_tick, output record_left,
                  output record_right, input ready);
  modport sink (input valid, input event_kind, input record_tick, input record_left,
                input record_right, output ready);
endinterface

### hw/rtl/sodr_cfg_if.sv
// Configuration write channel: register index and write data.
interface sodr_cfg_if;
  import sodr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/sodr_lane.sv
// One voltage lane: last recorded value and the delta-over-threshold test.
module sodr_lane import sodr_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic [THR_W-1:0]              threshold_i,
  input  logic                          commit_i,
  output logic                          changed_o
);

  localparam int CMP_W = (SAMPLE_BITS + 1 > THR_W) ? SAMPLE_BITS + 1 : THR_W;

  logic signed [SAMPLE_BITS-1:0] last_q, last_d;
  logic signed [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS:0]          diff_u;
  logic [SAMPLE_BITS:0]          mag;

  assign diff   = {last_q[SAMPLE_BITS-1], last_q} - {sample_i[SAMPLE_BITS-1], sample_i};
  assign diff_u = diff;
  assign mag    = diff_u[SAMPLE_BITS] ? (~diff_u + 1'b1) : diff_u;

  assign changed_o = CMP_W'(mag) > CMP_W'(threshold_i);

  assign last_d = commit_i ? sample_i : last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else begin
      last_q <= last_d;
    end
  end

endmodule

### hw/rtl/sodr_merge.sv
// Merge stage: tick counter, window control and the registered result.
module sodr_merge import sodr_pkg::*; #(
  parameter int TICK_BITS   = TICK_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [WIN_W-1:0]              win_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] left_i,
  input  logic signed [SAMPLE_BITS-1:0] right_i,
  input  lane_hits_t                    hits_i,
  output logic                          commit_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          event_kind_o,
  output logic [TICK_BITS-1:0]          record_tick_o,
  output logic signed [SAMPLE_BITS-1:0] record_left_o,
  output logic signed [SAMPLE_BITS-1:0] record_right_o
);

  logic [TICK_BITS-1:0]          tick_q, tick_d;
  logic                          has_rec_q, has_rec_d;
  logic                          valid_q, valid_d;
  logic                          kind_q, kind_d;
  logic [TICK_BITS-1:0]          otick_q, otick_d;
  logic signed [SAMPLE_BITS-1:0] oleft_q, oleft_d;
  logic signed [SAMPLE_BITS-1:0] oright_q, oright_d;

  logic [TICK_BITS-1:0] win;
  logic [TICK_BITS-1:0] last_pos;
  logic [TICK_BITS-1:0] tick_inc;
  logic                 accept;
  logic                 emit;

  assign win        = TICK_BITS'(win_i);
  assign last_pos   = win - 1'b1;
  assign tick_inc   = tick_q + 1'b1;
  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    tick_d    = tick_q;
    has_rec_d = has_rec_q;
    kind_d    = kind_q;
    otick_d   = otick_q;
    oleft_d   = oleft_q;
    oright_d  = oright_q;
    commit_o  = 1'b0;
    emit      = 1'b0;
    if (accept) begin
      if (tick_q == last_pos) begin
        emit     = 1'b1;
        tick_d   = tick_inc;
        kind_d   = EVT_WINDOW_END;
        otick_d  = tick_q;
        oleft_d  = '0;
        oright_d = '0;
      end else if (tick_q != win) begin
        tick_d = tick_inc;
        if (hits_i.left || hits_i.right) begin
          emit      = 1'b1;
          commit_o  = 1'b1;
          has_rec_d = 1'b1;
          tick_d    = has_rec_q ? tick_inc : '0;
          kind_d    = EVT_RECORD;
          otick_d   = has_rec_q ? tick_inc : '0;
          oleft_d   = left_i;
          oright_d  = right_i;
        end
      end
    end
  end

  always_comb begin
    if (emit) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= '0;
      has_rec_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      tick_q    <= tick_d;
      has_rec_q <= has_rec_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    otick_q  <= otick_d;
    oleft_q  <= oleft_d;
    oright_q <= oright_d;
  end

  assign out_valid_o    = valid_q;
  assign event_kind_o   = kind_q;
  assign record_tick_o  = otick_q;
  assign record_left_o  = oleft_q;
  assign record_right_o = oright_q;

endmodule

### hw/rtl/send_on_delta_drive_recorder.sv
// Send-on-delta drive recorder: top level with configuration registers.
//
// in_i carries one sampling tick per item: a left and a right drive voltage.
// out_o carries records (event_kind 0) and the window-end event (event_kind 1).
// cfg_i writes ticks_in_window (index 0) and change_threshold (index 1); it is
// always ready and takes effect on the next item.
// Two lanes compare each voltage against its last recorded value in parallel;
// the merge stage runs the tick counter and registers the result.
// A result appears on out_o in the cycle after its item is accepted.
// Throughput: one item per cycle while out_o takes each result, set by the single output register.
// A stalled receiver holds the result; in_i stays ready as long as the held
// result is taken in the same cycle, so one result is buffered at most.
// Reset clears the tick count, the record flag and the last recorded pair,
// loads ticks_in_window = 300 and change_threshold = 15, and empties out_o.
// After the window end every further item is accepted and dropped.
module send_on_delta_drive_recorder import sodr_pkg::*; #(
  parameter int TICK_BITS   = TICK_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  sodr_in_if.sink   in_i,
  sodr_out_if.source out_o,
  sodr_cfg_if.sink  cfg_i
);

`include "send_on_delta_drive_recorder_macros.svh"

  logic [WIN_W-1:0] win_q, win_d;
  logic [THR_W-1:0] thr_q, thr_d;
  lane_hits_t       hits;
  logic             commit;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    win_d = win_q;
    thr_d = thr_q;
    if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_TICKS_IN_WINDOW:  win_d = cfg_i.data[WIN_W-1:0];
        REG_CHANGE_THRESHOLD: thr_d = cfg_i.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WIN_RESET;
      thr_q <= THR_RESET;
    end else begin
      win_q <= win_d;
      thr_q <= thr_d;
    end
  end

  sodr_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_left (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (in_i.left_voltage),
    .threshold_i (thr_q),
    .commit_i    (commit),
    .changed_o   (hits.left)
  );

  sodr_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_right (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (in_i.right_voltage),
    .threshold_i (thr_q),
    .commit_i    (commit),
    .changed_o   (hits.right)
  );

  sodr_merge #(.TICK_BITS(TICK_BITS), .SAMPLE_BITS(SAMPLE_BITS)) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .win_i          (win_q),
    .in_valid_i     (in_i.valid),
    .in_ready_o     (in_i.ready),
    .left_i         (in_i.left_voltage),
    .right_i        (in_i.right_voltage),
    .hits_i         (hits),
    .commit_o       (commit),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .event_kind_o   (out_o.event_kind),
    .record_tick_o  (out_o.record_tick),
    .record_left_o  (out_o.record_left),
    .record_right_o (out_o.record_right)
  );

  `SODR_ASSERT(a_no_accept_into_stall, clk_i, rst_ni, !(in_i.valid && in_i.ready && out_o.valid && !out_o.ready))
  `SODR_ASSERT(a_window_end_zero, clk_i, rst_ni, !(out_o.valid && (out_o.event_kind == EVT_WINDOW_END) && ((out_o.record_left != '0) || (out_o.record_right != '0))))
  `SODR_ASSERT_NEXT(a_commit_shows, clk_i, rst_ni, commit, out_o.valid && (out_o.event_kind == EVT_RECORD))

endmodule

### dv/send_on_delta_drive_recorder_tb.sv
// Testbench for the send-on-delta drive recorder: random drive ticks checked against a predictor.
`timescale 1ns / 1ps

module send_on_delta_drive_recorder_tb;
  import sodr_pkg::*;

  localparam int TK_W        = TICK_BITS_DEF;
  localparam int SV_W        = SAMPLE_BITS_DEF;
  localparam int IDLE_LIMIT  = 2000;
  localparam int LIVE_TARGET = 1400;

  typedef logic [TK_W-1:0]        tick_t;
  typedef logic signed [SV_W-1:0] volt_t;

  typedef struct {
    logic  kind;
    tick_t tick;
    volt_t left;
    volt_t right;
  } drive_record_t;

  class drive_record_sb;
    tick_t            win_len;
    logic [THR_W-1:0] delta_thr;
    tick_t            tick_pos;
    bit               recorded;
    volt_t            rec_left;
    volt_t            rec_right;
    drive_record_t    pending_records[$];
    int               live_ticks;
    int               errors;

    function new();
      win_len    = WIN_RESET;
      delta_thr  = THR_RESET;
      tick_pos   = '0;
      recorded   = 1'b0;
      rec_left   = '0;
      rec_right  = '0;
      live_ticks = 0;
      errors     = 0;
    endfunction

    function automatic int mag(int v);
      return (v < 0) ? -v : v;
    endfunction

    function void note_reg_write(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TICKS_IN_WINDOW: begin
          win_len = data[TK_W-1:0];
        end
        REG_CHANGE_THRESHOLD: begin
          delta_thr = data[THR_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void note_tick(volt_t l, volt_t r);
      drive_record_t rec;
      bit            changed;
      int            thr;
      thr = int'(delta_thr);
      if (tick_pos == tick_t'(win_len - 1'b1)) begin
        rec.kind  = EVT_WINDOW_END;
        rec.tick  = tick_pos;
        rec.left  = '0;
        rec.right = '0;
        pending_records.insert(pending_records.size(), rec);
        tick_pos = tick_pos + 1'b1;
        live_ticks++;
        return;
      end
      if (tick_pos == win_len) return;
      live_ticks++;
      tick_pos = tick_pos + 1'b1;
      if (!recorded) begin
        changed = mag(int'(l)) > thr || mag(int'(r)) > thr;
      end else begin
        changed = mag(int'(rec_left) - int'(l)) > thr || mag(int'(rec_right) - int'(r)) > thr;
      end
      if (!changed) return;
      if (!recorded) tick_pos = '0;
      recorded  = 1'b1;
      rec_left  = l;
      rec_right = r;
      rec.kind  = EVT_RECORD;
      rec.tick  = tick_pos;
      rec.left  = l;
      rec.right = r;
      pending_records.insert(pending_records.size(), rec);
    endfunction

    task report_mismatch(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_record(logic kind, tick_t tick, volt_t l, volt_t r);
      drive_record_t exp_rec;
      if (pending_records.size() == 0) begin
        report_mismatch($sformatf("unexpected item kind %0b tick %0d left %0d right %0d",
                                  kind, tick, l, r));
        return;
      end
      exp_rec = pending_records.pop_front();
      if (kind !== exp_rec.kind)
        report_mismatch($sformatf("event_kind %0b, want %0b", kind, exp_rec.kind));
      if (tick !== exp_rec.tick)
        report_mismatch($sformatf("record_tick %0d, want %0d", tick, exp_rec.tick));
      if (l !== exp_rec.left)
        report_mismatch($sformatf("record_left %0d, want %0d", l, exp_rec.left));
      if (r !== exp_rec.right)
        report_mismatch($sformatf("record_right %0d, want %0d", r, exp_rec.right));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  always #2 clk_i = ~clk_i;

  sodr_in_if #(.SAMPLE_BITS(SV_W)) in_if ();
  sodr_out_if #(.TICK_BITS(TK_W), .SAMPLE_BITS(SV_W)) out_if ();
  sodr_cfg_if cfg_if ();

  send_on_delta_drive_recorder #(
    .TICK_BITS   (TK_W),
    .SAMPLE_BITS (SV_W)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  drive_record_sb sb;
  bit             send_calm   = 1'b0;
  bit             sink_calm   = 1'b0;
  bit             no_gaps     = 1'b0;
  int             sink_stall  = 0;
  int             idle_cycles = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic volt_t pick_volt(volt_t base, int thr);
    int r;
    int v;
    int span;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      span = thr + thr / 2 + 4;
      v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
    end else if (r < 88) begin
      v = int'($urandom_range(0, 24000)) - 12000;
    end else begin
      return volt_t'($urandom);
    end
    if (v > 16383) v = 16383;
    if (v < -16384) v = -16384;
    return volt_t'(v);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      sink_stall   <= 0;
    end else if (sink_stall > 0) begin
      out_if.ready <= 1'b0;
      sink_stall   <= sink_stall - 1;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 399) == 0) sink_calm <= !sink_calm;
      if (!sink_calm) sink_stall <= gap_len();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_record(out_if.event_kind, out_if.record_tick, out_if.record_left,
                      out_if.record_right);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_tick(input volt_t l, input volt_t r);
    int gap;
    if ($urandom_range(0, 149) == 0) send_calm = !send_calm;
    gap = (no_gaps || send_calm) ? 0 : gap_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.left_voltage  <= l;
    in_if.right_voltage <= r;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_tick(l, r);
  endtask

  // hold off until every pending item is out and the pipeline is empty
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending_records.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic load_regs(input tick_t win, input logic [CFG_DATA_W-1:0] thr_word);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_TICKS_IN_WINDOW;
    cfg_if.data  <= CFG_DATA_W'(win);
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.note_reg_write(REG_TICKS_IN_WINDOW, CFG_DATA_W'(win));
    cfg_if.index <= REG_CHANGE_THRESHOLD;
    cfg_if.data  <= thr_word;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.note_reg_write(REG_CHANGE_THRESHOLD, thr_word);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    int                    r;
    int                    phase_items;
    tick_t                 win;
    logic [CFG_DATA_W-1:0] thr_word;
    sb = new();
    rst_ni              <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.left_voltage  <= '0;
    in_if.right_voltage <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= REG_TICKS_IN_WINDOW;
    cfg_if.data         <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero-length window: everything dropped
    load_regs(16'd0, CFG_DATA_W'(THR_RESET));
    send_tick(100, 100);
    send_tick(-100, 5);
    // one-tick window: end at once, then dropped
    settle();
    load_regs(16'd1, CFG_DATA_W'(THR_RESET));
    send_tick(200, 0);
    send_tick(300, 300);
    // widest window, first record and change tests
    settle();
    load_regs(16'hFFFF, 16'd15);
    send_tick(0, 0);
    send_tick(15, -15);
    send_tick(-16, 0);
    send_tick(-1, -15);
    send_tick(-16, 16);
    send_tick(-16384, 16383);
    send_tick(16383, -16384);
    send_tick(16383, -16384);
    settle();
    load_regs(16'hFFFF, 16'd0);
    send_tick(16383, -16384);
    send_tick(16382, -16384);
    settle();
    load_regs(16'hFFFF, 16'hFFFF);
    send_tick(-16384, 16383);
    settle();
    load_regs(16'hFFFF, 16'd24000);
    send_tick(-16384, 16383);
    // window end after records
    settle();
    load_regs(sb.tick_pos + tick_t'(3), 16'd15);
    send_tick(0, 0);
    send_tick(0, 0);
    send_tick(5000, 5000);
    send_tick(-5000, 0);

    while (sb.live_ticks < LIVE_TARGET) begin
      settle();
      r = $urandom_range(0, 99);
      if (r < 75) win = sb.tick_pos + tick_t'($urandom_range(2, 80));
      else if (r < 88) win = sb.tick_pos + tick_t'($urandom_range(150, 500));
      else if (r < 94) win = '1;
      else win = tick_t'($urandom_range(1, sb.tick_pos));
      r = $urandom_range(0, 99);
      if (r < 45) thr_word = CFG_DATA_W'($urandom_range(0, 150));
      else if (r < 75) thr_word = CFG_DATA_W'($urandom_range(150, 2000));
      else if (r < 90) thr_word = CFG_DATA_W'($urandom_range(2000, 24000));
      else if (r < 95) thr_word = '0;
      else thr_word = CFG_DATA_W'($urandom);
      load_regs(win, thr_word);
      phase_items = $urandom_range(20, 150);
      for (int i = 0; i < phase_items && sb.tick_pos != sb.win_len; i++) begin
        send_tick(pick_volt(sb.rec_left, int'(sb.delta_thr)),
                  pick_volt(sb.rec_right, int'(sb.delta_thr)));
      end
      repeat ($urandom_range(0, 2)) send_tick(volt_t'($urandom), volt_t'($urandom));
    end

    // window zero with the count past it: keep counting past the window
    settle();
    load_regs('0, 16'd15);
    no_gaps = 1'b1;
    repeat (40) send_tick(pick_volt(sb.rec_left, 15), pick_volt(sb.rec_right, 15));
    no_gaps = 1'b0;
    send_tick(1, 2);
    send_tick(-3, 4);

    settle();
    if (sb.pending_records.size() != 0)
      sb.report_mismatch($sformatf("%0d items never arrived", sb.pending_records.size()));
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### send_on_delta_drive_recorder.f
+incdir+hw/rtl
hw/rtl/sodr_pkg.sv
hw/rtl/sodr_in_if.sv
hw/rtl/sodr_out_if.sv
hw/rtl/sodr_cfg_if.sv
hw/rtl/sodr_lane.sv
hw/rtl/sodr_merge.sv
hw/rtl/send_on_delta_drive_recorder.sv
dv/send_on_delta_drive_recorder_tb.sv
